// ===== sv/kem_pkg.sv =====
// ----------------------------------------------------------------------------
// kem_pkg
// Shared constants, types and helper functions for the keyword matcher.
// ----------------------------------------------------------------------------
package kem_pkg;

  localparam int MAX_KEYWORDS = 6;
  localparam int MAX_CHARS    = 8;
  localparam int CHAR_W       = 8;
  localparam int KW_W         = MAX_CHARS * CHAR_W;
  localparam int POS_W        = $clog2(MAX_CHARS + 2);
  localparam int CNT_W        = 3;
  localparam int VERDICT_W    = 2;
  localparam int REG_COUNT    = MAX_KEYWORDS + 1;
  localparam int REG_IDX_W    = $clog2(REG_COUNT);
  localparam int ADDR_W       = REG_IDX_W + 3;
  localparam int DATA_W       = 64;

  localparam logic [REG_IDX_W-1:0] REG_KEYWORD_COUNT = REG_IDX_W'(MAX_KEYWORDS);
  localparam logic [CNT_W-1:0]     KW_COUNT_RESET    = CNT_W'(1);

  localparam logic [VERDICT_W-1:0] V_EMPTY = 2'd0;
  localparam logic [VERDICT_W-1:0] V_MATCH = 2'd1;
  localparam logic [VERDICT_W-1:0] V_BAD   = 2'd2;

  typedef enum logic [1:0] {
    PH_CHECK     = 2'd0,
    PH_CHECK_SEP = 2'd1,
    PH_END       = 2'd2,
    PH_SKIP      = 2'd3
  } phase_t;

  typedef logic [KW_W-1:0] keyword_t;

  typedef struct packed {
    keyword_t [MAX_KEYWORDS-1:0] keyword;
    logic [CNT_W-1:0]            keyword_count;
  } kem_cfg_t;

  typedef struct packed {
    phase_t                  phase;
    logic [MAX_KEYWORDS-1:0] alive;
    logic [POS_W-1:0]        pos;
    logic [VERDICT_W-1:0]    verdict;
  } kem_state_t;

  // index of the first zero byte, or MAX_CHARS
  function automatic logic [POS_W-1:0] kw_length(keyword_t kw);
    logic [POS_W-1:0] len;
    len = POS_W'(MAX_CHARS);
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (kw[i*CHAR_W +: CHAR_W] == '0) begin
        len = POS_W'(i);
      end
    end
    return len;
  endfunction

  // raw byte at a position, zero past the last slot
  function automatic logic [CHAR_W-1:0] kw_byte_at(keyword_t kw, logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] b;
    b = '0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (pos == POS_W'(i)) begin
        b = kw[i*CHAR_W +: CHAR_W];
      end
    end
    return b;
  endfunction

  function automatic logic [MAX_KEYWORDS-1:0] in_use_mask(logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0]        n;
    logic [MAX_KEYWORDS-1:0] mask;
    n = (cnt > CNT_W'(MAX_KEYWORDS)) ? CNT_W'(MAX_KEYWORDS) : cnt;
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      mask[k] = (CNT_W'(k) < n);
    end
    return mask;
  endfunction

endpackage

// ===== sv/kem_in_if.sv =====
// ----------------------------------------------------------------------------
// kem_in_if
// Character channel: one character with its separator and restart flags.
// ----------------------------------------------------------------------------
interface kem_in_if;
  logic                       valid;
  logic                       ready;
  logic [kem_pkg::CHAR_W-1:0] char_code;
  logic                       is_separator;
  logic                       first_char;

  modport source (output valid, output char_code, output is_separator,
                  output first_char, input ready);
  modport sink   (input valid, input char_code, input is_separator,
                  input first_char, output ready);
endinterface

// ===== sv/kem_out_if.sv =====
// ----------------------------------------------------------------------------
// kem_out_if
// Verdict channel: one verdict per character.
// ----------------------------------------------------------------------------
interface kem_out_if;
  logic                          valid;
  logic                          ready;
  logic [kem_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ===== sv/kem_regs.sv =====
// ----------------------------------------------------------------------------
// kem_regs
// APB register file holding the keywords and the keyword count.
// ----------------------------------------------------------------------------
module kem_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kem_pkg::ADDR_W-1:0]   paddr,
  input  logic [kem_pkg::DATA_W-1:0]   pwdata,
  output logic [kem_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output kem_pkg::kem_cfg_t            cfg
);
  import kem_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keyword       <= '0;
      cfg.keyword_count <= KW_COUNT_RESET;
    end else if (wr_en) begin
      if (idx < REG_KEYWORD_COUNT) begin
        cfg.keyword[idx] <= pwdata[KW_W-1:0];
      end else if (idx == REG_KEYWORD_COUNT) begin
        cfg.keyword_count <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < REG_KEYWORD_COUNT) begin
      prdata = DATA_W'(cfg.keyword[idx]);
    end else if (idx == REG_KEYWORD_COUNT) begin
      prdata = DATA_W'(cfg.keyword_count);
    end
  end

endmodule

// ===== sv/kem_match.sv =====
// ----------------------------------------------------------------------------
// kem_match
// One matching step: compares a character against all keywords in parallel
// and produces the next matcher state.
// ----------------------------------------------------------------------------
module kem_match (
  input  kem_pkg::kem_state_t          state,
  input  kem_pkg::kem_cfg_t            cfg,
  input  logic [kem_pkg::CHAR_W-1:0]   char_code,
  input  logic                         is_separator,
  input  logic                         first_char,
  output kem_pkg::kem_state_t          state_next
);
  import kem_pkg::*;

  kem_state_t              cur;
  logic [POS_W-1:0]        len [MAX_KEYWORDS];
  logic [MAX_KEYWORDS-1:0] hit;
  logic [MAX_KEYWORDS-1:0] survive;
  logic [POS_W-1:0]        last_len;
  logic [POS_W-1:0]        pos_inc;
  logic                    single;
  phase_t                  phase_next;

  // restart happens before the character is taken
  always_comb begin
    cur = state;
    if (first_char) begin
      cur.phase   = PH_CHECK;
      cur.verdict = V_EMPTY;
      cur.alive   = in_use_mask(cfg.keyword_count);
      cur.pos     = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      len[k] = kw_length(cfg.keyword[k]);
      hit[k] = ((cur.pos < len[k]) ? kw_byte_at(cfg.keyword[k], cur.pos) : '0) == char_code;
    end
  end

  assign survive = cur.alive & hit;
  assign single  = (survive != '0) && ((survive & (survive - 1'b1)) == '0);
  assign pos_inc = cur.pos + 1'b1;

  always_comb begin
    last_len = '0;
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      if (survive[k]) begin
        last_len = last_len | len[k];
      end
    end
  end

  // next phase
  always_comb begin
    phase_next = cur.phase;
    unique case (cur.phase)
      PH_CHECK: begin
        if (survive == '0) begin
          phase_next = PH_END;
        end else if (single && (pos_inc == last_len)) begin
          phase_next = PH_CHECK_SEP;
        end
      end
      PH_CHECK_SEP: phase_next = PH_END;
      PH_END:       phase_next = PH_SKIP;
      PH_SKIP:      phase_next = PH_SKIP;
      default:      phase_next = PH_SKIP;
    endcase
  end

  // datapath state
  always_comb begin
    state_next       = cur;
    state_next.phase = phase_next;
    unique case (cur.phase)
      PH_CHECK: begin
        state_next.alive = survive;
        if (cur.pos < POS_W'(MAX_CHARS)) begin
          state_next.pos = pos_inc;
        end
      end
      PH_CHECK_SEP: begin
        if (is_separator) begin
          state_next.verdict = V_MATCH;
        end
      end
      PH_END:  state_next.verdict = V_BAD;
      PH_SKIP: state_next.verdict = cur.verdict;
      default: state_next.verdict = cur.verdict;
    endcase
  end

endmodule

// ===== sv/keyword_elimination_matcher.sv =====
// ----------------------------------------------------------------------------
// keyword_elimination_matcher
// Matches a character stream against up to six keywords by eliminating
// candidates on mismatch; one verdict beat per character beat.
// ----------------------------------------------------------------------------
//   port     dir  kind        content
//   in_ch    in   valid/ready char_code, is_separator, first_char
//   out_ch   out  valid/ready verdict
//   apb      in   psel/pen    keyword_0..5 at 8*i, keyword_count at 0x30
//
// one character per cycle while out_ch is not stalled; a verdict beat becomes
// valid on out_ch after its character beat is taken (input register, then the
// match step into the verdict register)
// the matcher state is updated once per character as it moves to the output
// a stalled out_ch holds the verdict and the input register, then in_ch stalls
// rst is synchronous: keywords clear, count is one, matcher restarts
// ----------------------------------------------------------------------------
module keyword_elimination_matcher (
  input  logic                         clk,
  input  logic                         rst,
  kem_in_if.sink                       in_ch,
  kem_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kem_pkg::ADDR_W-1:0]   paddr,
  input  logic [kem_pkg::DATA_W-1:0]   pwdata,
  output logic [kem_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import kem_pkg::*;

  kem_cfg_t             cfg;
  kem_state_t           state;
  kem_state_t           state_next;

  logic                 s1_valid;
  logic [CHAR_W-1:0]    s1_char_code;
  logic                 s1_is_separator;
  logic                 s1_first_char;
  logic                 advance;
  logic                 in_ready;
  logic                 out_valid;
  logic [VERDICT_W-1:0] out_verdict;

  kem_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kem_match u_match (
    .state        (state),
    .cfg          (cfg),
    .char_code    (s1_char_code),
    .is_separator (s1_is_separator),
    .first_char   (s1_first_char),
    .state_next   (state_next)
  );

  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ready     = !s1_valid || advance;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.verdict = out_verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      state.phase   <= PH_CHECK;
      state.alive   <= in_use_mask(KW_COUNT_RESET);
      state.pos     <= '0;
      state.verdict <= V_EMPTY;
    end else begin
      if (in_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s1_char_code    <= in_ch.char_code;
      s1_is_separator <= in_ch.is_separator;
      s1_first_char   <= in_ch.first_char;
    end
    if (advance) begin
      out_verdict <= state_next.verdict;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ch.ready)
    else $error("input stalled without a full pipeline");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state.pos <= POS_W'(MAX_CHARS))
    else $error("character position past saturation");

  a_skip_bad: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SKIP |-> state.verdict == V_BAD)
    else $error("skip phase without bad verdict");

  a_check_empty: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_CHECK || state.phase == PH_END |-> state.verdict != V_BAD)
    else $error("bad verdict before end phase completed");

endmodule

// ===== tb/sv/keyword_elimination_matcher_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_elimination_matcher_test
// Drives character beats through the matcher and checks every verdict beat
// against a cycle-free model of the elimination matcher. A short table of
// directed tokens comes first, then random tokens and noise under six keyword
// settings, with random stalls on both channels except under the fifth setting.
// ----------------------------------------------------------------------------
module keyword_elimination_matcher_test;
  import kem_pkg::*;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int ITEMS_PER_SETTING = 134;
  localparam int FIRST_KEYWORD_ROW = 4;
  localparam int SETTINGS_RUN      = 6;

  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic                 sep;
    logic                 first;
    logic                 typed;
    logic [VERDICT_W-1:0] verdict;
  } token_row_t;

  logic clk = 1'b0;
  logic rst;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  kem_in_if  in_ch ();
  kem_out_if out_ch ();

  keyword_elimination_matcher u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // matcher model: registers and running state
  keyword_t                kw [MAX_KEYWORDS];
  logic [CNT_W-1:0]        kw_count;
  phase_t                  m_phase;
  logic [MAX_KEYWORDS-1:0] m_alive;
  int                      m_pos;
  logic [VERDICT_W-1:0]    m_verdict;

  logic [VERDICT_W-1:0] verdict_q [$];
  int                   mismatches = 0;
  int                   beats_sent = 0;
  bit                   idling_on  = 1'b1;
  int                   cycle_count;

  // first char in the low byte, first input character at index 0 of the string
  token_row_t token_rows [0:23] = '{
    '{"a",   1'b0, 1'b1, 1'b1, V_EMPTY},   // empty keyword dies on a letter
    '{"b",   1'b1, 1'b0, 1'b1, V_BAD},
    '{8'h00, 1'b0, 1'b1, 1'b1, V_EMPTY},   // zero char matches past the end
    '{8'hff, 1'b1, 1'b0, 1'b1, V_EMPTY},
    '{"i",   1'b0, 1'b1, 1'b1, V_EMPTY},
    '{"f",   1'b0, 1'b0, 1'b1, V_EMPTY},
    '{" ",   1'b1, 1'b0, 1'b1, V_MATCH},
    '{"i",   1'b0, 1'b1, 1'b1, V_EMPTY},   // "in" is a prefix of "int"
    '{"n",   1'b0, 1'b0, 1'b1, V_EMPTY},
    '{"t",   1'b0, 1'b0, 1'b1, V_EMPTY},
    '{";",   1'b1, 1'b0, 1'b1, V_MATCH},
    '{"i",   1'b0, 1'b1, 1'b1, V_EMPTY},
    '{"f",   1'b0, 1'b0, 1'b1, V_EMPTY},
    '{"x",   1'b0, 1'b0, 1'b1, V_EMPTY},   // no separator after a full keyword
    '{"y",   1'b0, 1'b0, 1'b1, V_BAD},
    '{8'hff, 1'b0, 1'b1, 1'b0, V_EMPTY},   // eight-byte all-ones keyword
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'hff, 1'b0, 1'b0, 1'b0, V_EMPTY},
    '{8'h00, 1'b1, 1'b0, 1'b0, V_EMPTY}
  };

  int setting_count [SETTINGS_RUN] = '{6, 1, 7, 0, 3, 6};

  function automatic int key_len(keyword_t w);
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (w[8*i +: 8] == 8'h00) return i;
    end
    return MAX_CHARS;
  endfunction

  function automatic logic [CHAR_W-1:0] key_char(int k, int pos);
    if (pos >= key_len(kw[k])) return 8'h00;
    return kw[k][8*pos +: 8];
  endfunction

  function automatic logic [MAX_KEYWORDS-1:0] keys_in_use();
    int n;
    n = (int'(kw_count) > MAX_KEYWORDS) ? MAX_KEYWORDS : int'(kw_count);
    return MAX_KEYWORDS'((1 << n) - 1);
  endfunction

  function automatic void restart_matcher();
    m_phase   = PH_CHECK;
    m_verdict = V_EMPTY;
    m_alive   = keys_in_use();
    m_pos     = 0;
  endfunction

  function automatic logic [VERDICT_W-1:0] next_verdict(logic [CHAR_W-1:0] c, logic sep,
                                                        logic first);
    int hits;
    int last;
    hits = 0;
    last = 0;
    if (first) restart_matcher();
    case (m_phase)
      PH_CHECK: begin
        for (int k = 0; k < MAX_KEYWORDS; k++) begin
          if (m_alive[k]) begin
            if (key_char(k, m_pos) != c) begin
              m_alive[k] = 1'b0;
            end else begin
              hits++;
              last = k;
            end
          end
        end
        if (hits == 0) begin
          m_phase = PH_END;
        end else if (hits == 1 && m_pos + 1 == key_len(kw[last])) begin
          m_phase = PH_CHECK_SEP;
        end
        if (m_pos < MAX_CHARS) m_pos++;
      end
      PH_CHECK_SEP: begin
        if (sep) m_verdict = V_MATCH;
        m_phase = PH_END;
      end
      PH_END: begin
        m_verdict = V_BAD;
        m_phase   = PH_SKIP;
      end
      default: begin
      end
    endcase
    return m_verdict;
  endfunction

  function automatic keyword_t pack_word(string s);
    keyword_t w;
    w = '0;
    for (int i = 0; i < s.len() && i < MAX_CHARS; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  // few letters so keywords often share prefixes
  function automatic keyword_t short_word(int maxlen);
    keyword_t w;
    int       n;
    w = '0;
    n = $urandom_range(1, maxlen);
    for (int i = 0; i < n; i++) w[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < MAX_KEYWORDS) begin
      kw[idx] = val;
    end else begin
      kw_count = val[CNT_W-1:0];
    end
  endtask

  task automatic end_apb();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_all_verdicts();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // valid stays high from one beat to the next unless a gap is drawn
  task automatic send_beat(input logic [CHAR_W-1:0] c, input logic s, input logic f,
                           input logic typed = 1'b0,
                           input logic [VERDICT_W-1:0] tv = V_EMPTY);
    logic [VERDICT_W-1:0] pv;
    while (idling_on && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.is_separator <= s;
    in_ch.first_char   <= f;
    do @(posedge clk); while (!in_ch.ready);
    pv = next_verdict(c, s, f);
    verdict_q = {verdict_q, (typed ? tv : pv)};
    beats_sent++;
  endtask

  task automatic send_token();
    int                k;
    int                len;
    int                n;
    int                bad_at;
    logic [CHAR_W-1:0] c;
    k      = $urandom_range(0, MAX_KEYWORDS - 1);
    len    = key_len(kw[k]);
    n      = len;
    if ($urandom_range(0, 99) < 15) n = $urandom_range(0, MAX_CHARS + 2);
    bad_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i < len) begin
        c = kw[k][8*i +: 8];
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      if (i == bad_at) c = c ^ (8'h01 << $urandom_range(0, 7));
      send_beat(c, $urandom_range(0, 99) < 5, (i == 0) ? ($urandom_range(0, 99) < 90) : 1'b0);
    end
    // terminator, mostly a separator
    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 75, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 99) < 20);
    end
  endtask

  task automatic load_setting(input int p);
    keyword_t w;
    int       n;
    int       cut;
    for (int k = 0; k < MAX_KEYWORDS; k++) begin
      case (p)
        1: begin
          w = '0;
          n = $urandom_range(0, MAX_CHARS);
          for (int i = 0; i < n; i++) w[8*i +: 8] = 8'($urandom_range(1, 255));
        end
        3: w = {$urandom, $urandom};
        5: begin
          if (k == 0) begin
            w = '1;
          end else if (k == 1) begin
            w = '0;
          end else begin
            w = short_word(MAX_CHARS);
          end
        end
        default: begin
          if (k > 0 && $urandom_range(0, 99) < 35) begin
            // prefix of the previous keyword
            w   = kw[k-1];
            cut = $urandom_range(1, MAX_CHARS - 1);
            for (int i = cut; i < MAX_CHARS; i++) w[8*i +: 8] = 8'h00;
          end else begin
            w = short_word((p == 0) ? 3 : MAX_CHARS);
          end
        end
      endcase
      write_reg(k, w);
    end
    write_reg(REG_KEYWORD_COUNT, DATA_W'(setting_count[p]));
    end_apb();
  endtask

  // verdict sink with random backpressure
  initial begin
    logic [VERDICT_W-1:0] want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict beat %0d with nothing pending", out_ch.verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.verdict !== want) begin
            report_mismatch($sformatf("verdict got %0d want %0d", out_ch.verdict, want));
          end
        end
      end
      out_ch.ready <= !(idling_on && $urandom_range(0, 99) < 23);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase_start;
    bit paused;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.char_code    <= '0;
    in_ch.is_separator <= 1'b0;
    in_ch.first_char   <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    for (int k = 0; k < MAX_KEYWORDS; k++) kw[k] = '0;
    kw_count = KW_COUNT_RESET;
    restart_matcher();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(token_rows); i++) begin
      if (i == FIRST_KEYWORD_ROW) begin
        wait_all_verdicts();
        write_reg(0, pack_word("if"));
        write_reg(1, pack_word("int"));
        write_reg(2, pack_word("in"));
        write_reg(3, pack_word("abcdefgh"));
        write_reg(4, '1);
        write_reg(5, pack_word("for"));
        write_reg(REG_KEYWORD_COUNT, DATA_W'(MAX_KEYWORDS));
        end_apb();
      end
      send_beat(token_rows[i].ch, token_rows[i].sep, token_rows[i].first,
                token_rows[i].typed, token_rows[i].verdict);
    end

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      wait_all_verdicts();
      idling_on = (p != 4);
      load_setting(p);
      phase_start = beats_sent;
      paused      = 1'b0;
      while (beats_sent - phase_start < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 99) < 75) begin
          send_token();
        end else begin
          send_noise();
        end
        if (!paused && beats_sent - phase_start >= ITEMS_PER_SETTING / 2) begin
          wait_all_verdicts();
          paused = 1'b1;
        end
      end
    end

    wait_all_verdicts();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
